### design/thermal_hot_pixel_centroid_top_macros.svh
// Assertion macros shared by the checkers of the hot pixel centroid block.
// They expect clk and rst_n in scope.
`ifndef THERMAL_HOT_PIXEL_CENTROID_TOP_MACROS_SVH
`define THERMAL_HOT_PIXEL_CENTROID_TOP_MACROS_SVH

// same-cycle implication
`define THC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thc assertion failed");

// next-cycle implication
`define THC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thc assertion failed");

`endif

### design/thc_pkg.sv
`default_nettype none
package thc_pkg;

    localparam int FRAME_WIDTH = 320;

    localparam int PIX_W = 8;
    localparam int THR_W = 8;
    localparam int FOV_W = 16;
    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int WCS_W = 31;
    localparam int WS_W  = 23;
    localparam int CNT_W = 17;
    localparam int CX_W  = 17;
    localparam int BRG_W = 16;

    localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + CNT_W + CX_W + BRG_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // output word layout, lowest bit first
    localparam int OUT_FIRE_LSB = 0;
    localparam int OUT_CNT_LSB  = OUT_FIRE_LSB + 1;
    localparam int OUT_CX_LSB   = OUT_CNT_LSB + CNT_W;
    localparam int OUT_BRG_LSB  = OUT_CX_LSB + CX_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FOV_W;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OF_VIEW = 1'b1;
    localparam logic [THR_W-1:0] THR_RESET = 8'd180;
    localparam logic [FOV_W-1:0] FOV_RESET = 16'd34308;

    // centroid clamp
    localparam longint CX_LIM_FRAME = longint'(FRAME_WIDTH - 1) * 256;
    localparam longint CX_MAX       = (longint'(1) << CX_W) - 1;
    localparam longint CX_LIM       = (CX_LIM_FRAME < CX_MAX) ? CX_LIM_FRAME : CX_MAX;

    // bearing arithmetic
    localparam longint HALF_FRAME = longint'(FRAME_WIDTH) * 128;
    localparam longint BRG_DEN    = longint'(FRAME_WIDTH) * 256;
    localparam int     HALF_W     = $clog2(HALF_FRAME + 1);
    localparam int     DIFF_W     = ((HALF_W > CX_W) ? HALF_W : CX_W) + 1;
    localparam int     PROD_W     = DIFF_W + FOV_W + 1;
    localparam longint BRG_POS_MAX = (longint'(1) << (BRG_W - 1)) - 1;
    localparam longint BRG_NEG_MAG = longint'(1) << (BRG_W - 1);

    // bearing scale: drop the Q.8 part, then divide by the frame width
    // through a rounded-up reciprocal that is exact over BRG_T_W bits
    localparam int     BRG_T_W    = PROD_W - 8;
    localparam int     BRG_RCP_SH = BRG_T_W + $clog2(FRAME_WIDTH);
    localparam longint BRG_RCP    = ((longint'(1) << BRG_RCP_SH) + FRAME_WIDTH - 1) /
                                    FRAME_WIDTH;
    localparam int     BRG_RCP_W  = $clog2(BRG_RCP + 1);
    localparam int     BRG_Q_W    = BRG_T_W + BRG_RCP_W;
    localparam int     BRG_QB_W   = BRG_Q_W - BRG_RCP_SH;

    // centroid divider
    localparam int DVD_W  = WCS_W + 9;
    localparam int DVR_W  = WS_W;
    localparam int DCNT_W = $clog2(DVD_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [WS_W-1:0]  ws;
        logic [WCS_W-1:0] wcs;
    } frame_sums_t;

    typedef struct packed {
        logic        push;
        frame_sums_t sums;
    } sums_push_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

### design/thc_div.sv
`default_nettype none
module thc_div (
    input  wire              clk,
    input  wire              rst_n,
    input  thc_pkg::div_req_t req,
    output thc_pkg::div_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [thc_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [thc_pkg::DVR_W-1:0] rem_reg, rem_next;
    logic [thc_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [thc_pkg::DVR_W-1:0] dvr_reg, dvr_next;

    logic [thc_pkg::DVR_W:0] trial;
    logic [thc_pkg::DVR_W:0] trial_sub;
    logic                    ge;

    // restoring division, one quotient bit per cycle; quo_reg shifts the
    // dividend out at the top and the quotient in at the bottom
    always_comb
    begin
        trial     = {rem_reg, quo_reg[thc_pkg::DVD_W-1]};
        ge        = trial >= {1'b0, dvr_reg};
        trial_sub = trial - {1'b0, dvr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvr_next  = dvr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial_sub[thc_pkg::DVR_W-1:0] : trial[thc_pkg::DVR_W-1:0];
            quo_next = {quo_reg[thc_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == thc_pkg::DCNT_W'(thc_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvr_reg <= dvr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

### design/thc_front.sv
`default_nettype none
module thc_front (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [thc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire                             s_tlast,
    input  wire [thc_pkg::THR_W-1:0]        hot_threshold,
    input  wire                             fifo_full,
    output thc_pkg::sums_push_t             push
);

    logic [thc_pkg::COL_W-1:0] col_reg, col_next;
    logic [thc_pkg::WCS_W-1:0] wcs_reg, wcs_next;
    logic [thc_pkg::WS_W-1:0]  ws_reg, ws_next;
    logic [thc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic                                     accept;
    logic [thc_pkg::PIX_W-1:0]                pix;
    logic                                     hot;
    logic [thc_pkg::PIX_W-1:0]                weight;
    logic [thc_pkg::COL_W+thc_pkg::PIX_W-1:0] col_w;
    logic [thc_pkg::WCS_W:0]                  wcs_sum;
    logic [thc_pkg::WS_W:0]                   ws_sum;
    logic [thc_pkg::CNT_W:0]                  cnt_sum;
    thc_pkg::frame_sums_t                     upd;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign pix      = s_tdata[thc_pkg::PIX_W-1:0];
    assign hot      = pix >= hot_threshold;
    assign weight   = pix - hot_threshold;
    assign col_w    = col_reg * weight;

    // saturating accumulate: the carry out pins each sum at all ones
    assign wcs_sum = {1'b0, wcs_reg} + (thc_pkg::WCS_W + 1)'(col_w);
    assign ws_sum  = {1'b0, ws_reg} + (thc_pkg::WS_W + 1)'(weight);
    assign cnt_sum = {1'b0, cnt_reg} + 1'b1;

    always_comb
    begin
        upd.wcs = wcs_reg;
        upd.ws  = ws_reg;
        upd.cnt = cnt_reg;
        if (hot)
        begin
            upd.wcs = wcs_sum[thc_pkg::WCS_W] ? '1 : wcs_sum[thc_pkg::WCS_W-1:0];
            upd.ws  = ws_sum[thc_pkg::WS_W] ? '1 : ws_sum[thc_pkg::WS_W-1:0];
            upd.cnt = cnt_sum[thc_pkg::CNT_W] ? '1 : cnt_sum[thc_pkg::CNT_W-1:0];
        end

        col_next = col_reg;
        wcs_next = wcs_reg;
        ws_next  = ws_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            col_next = (col_reg == thc_pkg::COL_W'(thc_pkg::FRAME_WIDTH - 1)) ?
                       '0 : col_reg + 1'b1;
            if (s_tlast)
            begin
                col_next = '0;
                wcs_next = '0;
                ws_next  = '0;
                cnt_next = '0;
            end
            else
            begin
                wcs_next = upd.wcs;
                ws_next  = upd.ws;
                cnt_next = upd.cnt;
            end
        end
    end

    assign push.push = accept && s_tlast;
    assign push.sums = upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            wcs_reg <= '0;
            ws_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            wcs_reg <= wcs_next;
            ws_reg  <= ws_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

### design/thc_fifo.sv
`default_nettype none
module thc_fifo (
    input  wire                   clk,
    input  wire                   rst_n,
    input  thc_pkg::sums_push_t   push,
    input  wire                   pop,
    output thc_pkg::frame_sums_t  head,
    output logic                  full,
    output logic                  empty
);

    thc_pkg::frame_sums_t           mem_reg [thc_pkg::FIFO_DEPTH];
    logic [thc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [thc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [thc_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full    = count_reg == thc_pkg::FIFO_CNT_W'(thc_pkg::FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == thc_pkg::FIFO_PTR_W'(thc_pkg::FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == thc_pkg::FIFO_PTR_W'(thc_pkg::FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.sums;
        end
    end

endmodule
`default_nettype wire

### design/thc_back.sv
`default_nettype none
module thc_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire [thc_pkg::FOV_W-1:0]         field_of_view,
    input  wire                              fifo_empty,
    input  thc_pkg::frame_sums_t             head,
    output logic                             pop,
    output thc_pkg::div_req_t                div_req,
    input  thc_pkg::div_rsp_t                div_rsp,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [thc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIVC  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_MAG   = 7'b0001000,
        S_RECIP = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } back_state_t;

    back_state_t                       state_reg, state_next;
    logic [thc_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              valid_reg, valid_next;
    logic [thc_pkg::CX_W-1:0]          cx_reg, cx_next;
    logic signed [thc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                              neg_reg, neg_next;
    logic [thc_pkg::BRG_T_W-1:0]       t_reg, t_next;
    logic [thc_pkg::BRG_QB_W-1:0]      qb_reg, qb_next;
    logic [thc_pkg::BRG_W-1:0]         brg_reg, brg_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [thc_pkg::OUT_DATA_W-1:0]    m_data_reg, m_data_next;
    logic                              m_user_reg, m_user_next;

    logic signed [thc_pkg::DIFF_W-1:0] diff;
    logic signed [thc_pkg::FOV_W:0]    fov_s;
    logic signed [thc_pkg::PROD_W-1:0] prod;
    logic [thc_pkg::PROD_W-1:0]        mag;
    logic [thc_pkg::PROD_W-1:0]        mag_rnd;
    logic [thc_pkg::BRG_Q_W-1:0]       rcp_prod;
    logic [thc_pkg::DVD_W-1:0]         q;

    assign diff     = $signed(thc_pkg::DIFF_W'(thc_pkg::HALF_FRAME)) -
                      $signed(thc_pkg::DIFF_W'(cx_reg));
    assign fov_s    = $signed({1'b0, field_of_view});
    assign prod     = diff * fov_s;
    assign mag      = prod_reg[thc_pkg::PROD_W-1] ? thc_pkg::PROD_W'(-prod_reg) :
                                                    thc_pkg::PROD_W'(prod_reg);
    assign mag_rnd  = mag + thc_pkg::PROD_W'(thc_pkg::BRG_DEN / 2);
    assign rcp_prod = thc_pkg::BRG_Q_W'(t_reg) * thc_pkg::BRG_Q_W'(thc_pkg::BRG_RCP);
    assign q        = div_rsp.quotient;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        cx_next       = cx_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        t_next        = t_reg;
        qb_next       = qb_reg;
        brg_next      = brg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        pop           = 1'b0;
        div_req       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop      = 1'b1;
                    cnt_next = head.cnt;
                    if (head.ws == '0)
                    begin
                        valid_next = 1'b0;
                        cx_next    = '0;
                        brg_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // rounded centroid: (wcs * 256 + ws / 2) / ws
                        valid_next       = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = thc_pkg::DVD_W'({head.wcs, 8'h00}) +
                                           thc_pkg::DVD_W'(head.ws >> 1);
                        div_req.divisor  = head.ws;
                        state_next       = S_DIVC;
                    end
                end
            end
            S_DIVC:
            begin
                if (div_rsp.done)
                begin
                    cx_next = (q > thc_pkg::DVD_W'(thc_pkg::CX_LIM)) ?
                              thc_pkg::CX_W'(thc_pkg::CX_LIM) : q[thc_pkg::CX_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = prod;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                // round magnitude half away from zero, sign applied afterwards;
                // the low 8 bits of the divisor go first as a shift
                neg_next   = prod_reg[thc_pkg::PROD_W-1];
                t_next     = mag_rnd[thc_pkg::PROD_W-1:8];
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                qb_next    = rcp_prod[thc_pkg::BRG_Q_W-1:thc_pkg::BRG_RCP_SH];
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (!neg_reg)
                begin
                    brg_next = (qb_reg > thc_pkg::BRG_QB_W'(thc_pkg::BRG_POS_MAX)) ?
                               thc_pkg::BRG_W'(thc_pkg::BRG_POS_MAX) :
                               qb_reg[thc_pkg::BRG_W-1:0];
                end
                else
                begin
                    brg_next = (qb_reg > thc_pkg::BRG_QB_W'(thc_pkg::BRG_NEG_MAG)) ?
                               thc_pkg::BRG_W'(thc_pkg::BRG_NEG_MAG) :
                               -qb_reg[thc_pkg::BRG_W-1:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = thc_pkg::OUT_DATA_W'({brg_reg, cx_reg, cnt_reg,
                                                          cnt_reg != '0});
                    m_user_next   = valid_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        valid_reg  <= valid_next;
        cx_reg     <= cx_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        t_reg      <= t_next;
        qb_reg     <= qb_next;
        brg_reg    <= brg_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

### design/thermal_hot_pixel_centroid_top.sv
// Hot pixel centroid of a thermal frame.
// Input stream (s_*): one 8-bit pixel per word in raster order, tlast on the
// last pixel of a frame. One pixel is taken every cycle while tready is high.
// Output stream (m_*): one word per frame with the hot count, the centroid
// column (Q.8) and the bearing (Q1.15 rad); tuser is high when the centroid
// is valid (nonzero total weight).
// cfg_we/cfg_index/cfg_data write the threshold (index 0) and the field of
// view (index 1); write only while no frame is in flight.
// A frame with weight runs from the tlast word through the 40-step restoring
// divider for the centroid, then the bearing multiply, reciprocal scaling and
// saturation, to the result word; a weightless frame goes straight to the
// result word. The back end works on one frame at a time. Frame sums
// wait in a 2-entry queue, so pixels keep streaming while a result is
// computed; tready drops only while two frames wait behind the one in work.
// When m_tready is low the result word holds in the output register; the back
// end stalls and then the queue fills.
// Reset clears the accumulators, column counter, queue and output valid, and
// loads threshold 180 and field of view 34308.
`default_nettype none
module thermal_hot_pixel_centroid_top (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [thc_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] pixel
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [0] fire_seen, [17:1] hot_count, [34:18] centroid_x, [50:35] bearing, rest 0
    output logic [thc_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // [0] centroid_valid
    input  wire                               cfg_we,
    input  wire [thc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [thc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [thc_pkg::THR_W-1:0] thr_reg, thr_next;
    logic [thc_pkg::FOV_W-1:0] fov_reg, fov_next;

    thc_pkg::sums_push_t  push;
    thc_pkg::frame_sums_t head;
    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 pop;
    thc_pkg::div_req_t    div_req;
    thc_pkg::div_rsp_t    div_rsp;

    always_comb
    begin
        thr_next = thr_reg;
        fov_next = fov_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                thc_pkg::CFG_HOT_THRESHOLD: thr_next = cfg_data[thc_pkg::THR_W-1:0];
                thc_pkg::CFG_FIELD_OF_VIEW: fov_next = cfg_data[thc_pkg::FOV_W-1:0];
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= thc_pkg::THR_RESET;
            fov_reg <= thc_pkg::FOV_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
            fov_reg <= fov_next;
        end
    end

    thc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .hot_threshold (thr_reg),
        .fifo_full     (fifo_full),
        .push          (push)
    );

    thc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    thc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    thc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .field_of_view (fov_reg),
        .fifo_empty    (fifo_empty),
        .head          (head),
        .pop           (pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
`default_nettype wire

### design/thc_checker.sv
`default_nettype none
`include "thermal_hot_pixel_centroid_top_macros.svh"
module thc_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [thc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire                            m_tuser
);

    logic fire_bit;
    logic cnt_nz;
    logic upper_zero;

    assign fire_bit   = m_tdata[thc_pkg::OUT_FIRE_LSB];
    assign cnt_nz     = m_tdata[thc_pkg::OUT_CNT_LSB +: thc_pkg::CNT_W] != '0;
    assign upper_zero = m_tdata[thc_pkg::OUT_DATA_W-1:thc_pkg::OUT_CX_LSB] == '0;

    // a stalled result word stays up and unchanged
    `THC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `THC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // fire flag follows the hot count
    `THC_ASSERT_NOW(a_fire_cnt, m_tvalid, fire_bit == cnt_nz)

    // nonzero weight needs at least one hot pixel
    `THC_ASSERT_NOW(a_valid_fire, m_tvalid && m_tuser, fire_bit)

    // zero weight gives zero centroid and bearing
    `THC_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tuser, upper_zero)

endmodule

bind thermal_hot_pixel_centroid_top thc_checker u_thc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### tb/sv/thermal_hot_pixel_centroid_top_test.sv
`default_nettype none
module thermal_hot_pixel_centroid_top_test;
    import thc_pkg::*;

    typedef struct {
        logic               fire;
        logic               valid;
        logic [CNT_W-1:0]   count;
        logic [CX_W-1:0]    cx;
        logic [BRG_W-1:0]   bearing;
    } frame_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire [OUT_DATA_W-1:0]   m_tdata;
    wire                    m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [THR_W-1:0]       hot_thr = THR_RESET;
    logic [FOV_W-1:0]       fov = FOV_RESET;
    logic [COL_W-1:0]       col_pos = '0;
    logic [WCS_W-1:0]       col_weight_sum = '0;
    logic [WS_W-1:0]        weight_total = '0;
    logic [CNT_W-1:0]       hot_total = '0;

    frame_result_t          frame_results_due[$];
    int                     mismatches = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;

    thermal_hot_pixel_centroid_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Accumulate one accepted pixel; on end of frame queue the frame result.
    function automatic void accumulate_pixel(logic [PIX_W-1:0] pix, logic eof);
        longint w;
        longint prod;
        longint q;
        longint diff;
        longint num;
        longint mag;
        longint brg;
        frame_result_t res;
        if (pix >= hot_thr)
        begin
            w = longint'(pix) - longint'(hot_thr);
            prod = longint'(col_pos) * w;
            weight_total = (longint'(weight_total) + w > (longint'(1) << WS_W) - 1) ?
                '1 : WS_W'(longint'(weight_total) + w);
            col_weight_sum = (longint'(col_weight_sum) + prod > (longint'(1) << WCS_W) - 1) ?
                '1 : WCS_W'(longint'(col_weight_sum) + prod);
            hot_total = (hot_total == '1) ? hot_total : hot_total + 1'b1;
        end
        col_pos = (int'(col_pos) + 1 >= FRAME_WIDTH) ? '0 : col_pos + 1'b1;
        if (!eof)
            return;
        q = 0;
        brg = 0;
        res.valid = (weight_total != 0);
        if (res.valid)
        begin
            q = (longint'(col_weight_sum) * 256 + longint'(weight_total) / 2) /
                longint'(weight_total);
            if (q > CX_LIM)
                q = CX_LIM;
            diff = HALF_FRAME - q;
            num = diff * longint'(fov);
            mag = ((num < 0 ? -num : num) + BRG_DEN / 2) / BRG_DEN;
            brg = (num < 0) ? -mag : mag;
            if (brg > BRG_POS_MAX)
                brg = BRG_POS_MAX;
            if (brg < -BRG_NEG_MAG)
                brg = -BRG_NEG_MAG;
        end
        res.fire = (hot_total != 0);
        res.count = hot_total;
        res.cx = CX_W'(q);
        res.bearing = BRG_W'(brg);
        frame_results_due.push_back(res);
        col_pos = '0;
        col_weight_sum = '0;
        weight_total = '0;
        hot_total = '0;
    endfunction

    function automatic void compare_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("result word with none expected");
                mismatches++;
            end
            else
            begin
                due = frame_results_due.pop_front();
                compare_field("fire_seen", due.fire, m_tdata[OUT_FIRE_LSB]);
                compare_field("centroid_valid", due.valid, m_tuser);
                compare_field("hot_count", due.count, m_tdata[OUT_CNT_LSB +: CNT_W]);
                compare_field("centroid_x", due.cx, m_tdata[OUT_CX_LSB +: CX_W]);
                compare_field("bearing", $signed(due.bearing),
                              $signed(m_tdata[OUT_BRG_LSB +: BRG_W]));
            end
        end
    end

    task automatic send_pixel(logic [PIX_W-1:0] pix, logic eof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'(pix);
        s_tlast <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accumulate_pixel(pix, eof);
    endtask

    // Stop sending, wait for every queued frame result, then let the back end settle.
    task automatic drain_results(int settle);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (frame_results_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HOT_THRESHOLD)
            hot_thr = val[THR_W-1:0];
        else if (idx == CFG_FIELD_OF_VIEW)
            fov = val;
        @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 4)
            return PIX_W'($urandom_range(255));
        if (r < 9)
        begin
            v = int'(hot_thr) + $urandom_range(8) - 3;
            return PIX_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
        end
        return $urandom_range(1) ? 8'd255 : 8'd0;
    endfunction

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++)
            send_pixel(pick_pixel(), i == len - 1);
    endtask

    // Threshold boundary with the reset register values.
    task automatic test_reset_values();
        send_pixel(8'd180, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd179, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd181, 1'b1);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd100, 1'b1);
        drain_results(100);
    endtask

    task automatic test_register_extremes();
        // centroid at column zero with the widest view: bearing saturates high
        write_reg(CFG_HOT_THRESHOLD, 16'd0);
        write_reg(CFG_FIELD_OF_VIEW, 16'hFFFF);
        send_pixel(8'd255, 1'b1);
        // next frame: every pixel hot but weightless
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        drain_results(100);
        write_reg(CFG_HOT_THRESHOLD, 16'd255);
        write_reg(CFG_FIELD_OF_VIEW, 16'd0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd127, 1'b1);
        drain_results(100);
        write_reg(CFG_HOT_THRESHOLD, 16'd1);
        write_reg(CFG_FIELD_OF_VIEW, 16'hFFFF);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain_results(100);
    endtask

    // Column counter wraps inside one frame.
    task automatic test_column_wrap();
        write_reg(CFG_HOT_THRESHOLD, 16'd128);
        write_reg(CFG_FIELD_OF_VIEW, FOV_RESET);
        for (int i = 0; i < 330; i++)
            send_pixel((i == FRAME_WIDTH - 1) ? 8'd200 : (i == 325) ? 8'd140 : 8'd10,
                       i == 329);
        drain_results(100);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
        int items;
        int frames;
        int len;
        int r;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        items = 0;
        frames = 0;
        while (items < n_items || frames < 6)
        begin
            len = ($urandom_range(24) == 0) ? $urandom_range(400, 321) : $urandom_range(24, 1);
            send_frame(len);
            items += len;
            frames++;
            r = $urandom_range(15);
            if (r == 0)
            begin
                drain_results(100);
                r = $urandom_range(3);
                write_reg(CFG_HOT_THRESHOLD, (r == 0) ? 16'd0 : (r == 1) ? 16'd255 :
                          CFG_DATA_W'($urandom_range(255)));
                r = $urandom_range(3);
                write_reg(CFG_FIELD_OF_VIEW, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                          CFG_DATA_W'($urandom_range(65535)));
            end
            else if (r == 1)
                drain_results(0);
        end
        drain_results(100);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_register_extremes();
        test_column_wrap();
        write_reg(CFG_HOT_THRESHOLD, THR_RESET);
        write_reg(CFG_FIELD_OF_VIEW, FOV_RESET);
        test_random_phase(0, 0, 110);
        test_random_phase(66, 0, 110);
        test_random_phase(0, 66, 110);
        test_random_phase(25, 25, 110);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results(200);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(8 * 2000000);
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
